@@ hdl/rcr_pkg.sv @@
// Shared types, constants and the sRGB linearisation table for the contrast ratio block.
// Depends on nothing; every module of the block imports it.
package rcr_pkg;

    localparam int LUMA_FRAC_BITS  = 16;
    localparam int RATIO_FRAC_BITS = 8;

    localparam int COLOUR_W = 24;
    localparam int LUMA_W   = LUMA_FRAC_BITS + 1;     // linear value 0 .. 1.0 inclusive
    localparam int SUM_W    = LUMA_FRAC_BITS + 14;    // up to 10500 * 2^LUMA_FRAC_BITS
    localparam int RATIO_W  = RATIO_FRAC_BITS + 5;    // 1.0 .. 21.0
    localparam int NUM_W    = SUM_W + RATIO_FRAC_BITS;
    localparam int QUO_W    = RATIO_W;                // one quotient bit per cell

    localparam int WEIGHT_R = 2126;
    localparam int WEIGHT_G = 7152;
    localparam int WEIGHT_B = 722;
    localparam logic [SUM_W-1:0] SUM_OFFSET = SUM_W'(500) << LUMA_FRAC_BITS;

    localparam logic [RATIO_W-1:0] RATIO_LOWEST  = RATIO_W'(1) << RATIO_FRAC_BITS;
    localparam logic [RATIO_W-1:0] RATIO_HIGHEST = RATIO_W'(21) << RATIO_FRAC_BITS;
    localparam logic [RATIO_W-1:0] MIN_RATIO_RESET = RATIO_W'(9) << (RATIO_FRAC_BITS - 1);

    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned Q30_HALF = 64'd1 << 29;

    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [LUMA_W-1:0]   t_luma;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [RATIO_W-1:0]  t_ratio;
    typedef t_luma               t_lin_table [0:255];

    // One lane of the long division, handed from cell to cell.
    typedef struct packed {
        logic [SUM_W-1:0] divisor;
        logic [SUM_W-1:0] rem;
        logic [QUO_W-1:0] num;    // numerator bits still to be brought down, msb first
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    function automatic longint unsigned q30_mul(input longint unsigned x,
                                                input longint unsigned y);
        return (x * y + Q30_HALF) >> 30;
    endfunction

    // Linear light of one 8-bit channel: threshold branch, else power 2.4 as
    // ((c/255 + 0.055)/1.055)^2 times its fifth root.
    function automatic t_luma lin_channel(input int unsigned c);
        longint unsigned y;
        longint unsigned num;
        longint unsigned a;
        longint unsigned b;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned r2;
        longint unsigned r4;
        longint unsigned p;
        int              i;
        if (c <= 10) begin
            y = ((longint'(c) * 10) * Q30_ONE + 16473) / 32946;
        end else begin
            num = longint'(c) * 1000 + 14025;
            a   = (num * Q30_ONE + 134512) / 269025;
            b   = q30_mul(a, a);
            lo  = 0;
            hi  = Q30_ONE;
            for (i = 0; i < 32; i++) begin
                if (lo < hi) begin
                    mid = lo + ((hi - lo + 1) >> 1);
                    r2  = q30_mul(mid, mid);
                    r4  = q30_mul(r2, r2);
                    p   = q30_mul(r4, mid);
                    if (p <= b) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            y = q30_mul(b, lo);
        end
        return LUMA_W'((y + (64'd1 << (30 - LUMA_FRAC_BITS - 1))) >> (30 - LUMA_FRAC_BITS));
    endfunction

    function automatic t_lin_table build_lin_table();
        t_lin_table tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = lin_channel(i);
        end
        return tbl;
    endfunction

    localparam t_lin_table LIN_TABLE = build_lin_table();

endpackage

@@ hdl/rcr_luma.sv @@
// Luminance of one colour: table linearisation of each channel, then weighted sum plus 0.05.
// Depends on rcr_pkg. Two register stages, payload only.
module rcr_luma (
    input  logic            i_clk,
    input  rcr_pkg::t_colour i_colour,
    output rcr_pkg::t_sum    o_sum
);
    import rcr_pkg::*;

    t_luma r_lin_r;
    t_luma r_lin_g;
    t_luma r_lin_b;
    t_sum  r_sum;
    t_sum  n_sum;

    always_ff @(posedge i_clk) begin
        r_lin_r <= LIN_TABLE[i_colour[23:16]];
        r_lin_g <= LIN_TABLE[i_colour[15:8]];
        r_lin_b <= LIN_TABLE[i_colour[7:0]];
    end

    always_comb begin
        n_sum = SUM_W'(r_lin_r) * SUM_W'(WEIGHT_R)
              + SUM_W'(r_lin_g) * SUM_W'(WEIGHT_G)
              + SUM_W'(r_lin_b) * SUM_W'(WEIGHT_B)
              + SUM_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

@@ hdl/rcr_div_cell.sv @@
// One restoring-division cell: bring down a numerator bit, subtract when it fits.
// Depends on rcr_pkg.
module rcr_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  rcr_pkg::t_div_lane i_lane,
    output logic               o_vld,
    output rcr_pkg::t_div_lane o_lane
);
    import rcr_pkg::*;

    logic             r_vld;
    t_div_lane        r_lane;
    t_div_lane        n_lane;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             fits;

    always_comb begin
        trial  = {i_lane.rem, i_lane.num[QUO_W-1]};
        diff   = trial - {1'b0, i_lane.divisor};
        fits   = trial >= {1'b0, i_lane.divisor};
        n_lane.divisor = i_lane.divisor;
        n_lane.rem     = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        n_lane.num     = {i_lane.num[QUO_W-2:0], 1'b0};
        n_lane.quo     = {i_lane.quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

@@ hdl/rcr_divider.sv @@
// Row of division cells, one quotient bit per cell, a new lane entering every cycle.
// Depends on rcr_pkg and rcr_div_cell.
module rcr_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  rcr_pkg::t_div_lane i_lane,
    output logic               o_vld,
    output rcr_pkg::t_div_lane o_lane
);
    import rcr_pkg::*;

    logic      vld  [0:QUO_W];
    t_div_lane lane [0:QUO_W];

    assign vld[0]  = i_vld;
    assign lane[0] = i_lane;

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        rcr_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (vld[g]),
            .i_lane (lane[g]),
            .o_vld  (vld[g+1]),
            .o_lane (lane[g+1])
        );
    end

    assign o_vld  = vld[QUO_W];
    assign o_lane = lane[QUO_W];

endmodule

@@ hdl/rgb_contrast_ratio.sv @@
// WCAG 2 contrast ratio of two RGB colours, pipelined; depends on rcr_pkg, rcr_luma, rcr_divider.
// Throughput: one colour pair per clock; start is taken whenever busy is low.
// Pipeline: the edge that takes start loads the lookup registers, then weighting, ordering,
// 13 division cells and the output register behind o_strobe; the receiver cannot stall the pipe.
// Reset (synchronous, active low): valid flags clear, min_ratio returns to 4.5 and busy
// stays high until the first clock edge after reset is released.
module rgb_contrast_ratio (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rcr_pkg::t_colour i_fore_colour,
    input  rcr_pkg::t_colour i_back_colour,
    output rcr_pkg::t_ratio  o_ratio,
    output logic             o_meets_minimum,
    output logic             o_strobe,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  rcr_pkg::t_ratio  i_cfg_data
);
    import rcr_pkg::*;

    // Control: busy only covers the reset window, otherwise the pipe never fills up.
    logic      r_busy;
    logic      accept;

    // Valid flags following the two luma stages.
    logic      r_vld_lin;
    logic      r_vld_sum;

    t_sum      fore_sum;
    t_sum      back_sum;

    // Ordering stage: pick lighter and darker, form the rounded numerator.
    logic      r_vld_lane;
    t_div_lane r_lane;
    t_div_lane n_lane;
    t_sum      big;
    t_sum      small_sum;
    logic [NUM_W-1:0] numer;

    logic      div_vld;
    t_div_lane div_lane;

    // Output register and configuration.
    t_ratio    r_ratio;
    t_ratio    n_ratio;
    logic      r_meets;
    logic      r_strobe;
    t_ratio    r_min_ratio;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Configuration register: to be written only while the pipe is empty; the block does not check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ratio <= MIN_RATIO_RESET;
        end else if (i_cfg_valid) begin
            r_min_ratio <= i_cfg_data;
        end
    end

    rcr_luma u_fore_luma (
        .i_clk   (i_clk),
        .i_colour(i_fore_colour),
        .o_sum   (fore_sum)
    );

    rcr_luma u_back_luma (
        .i_clk   (i_clk),
        .i_colour(i_back_colour),
        .o_sum   (back_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lin  <= 1'b0;
            r_vld_sum  <= 1'b0;
            r_vld_lane <= 1'b0;
        end else begin
            r_vld_lin  <= accept;
            r_vld_sum  <= r_vld_lin;
            r_vld_lane <= r_vld_sum;
        end
    end

    // Numerator big * 2^RATIO_FRAC_BITS + small/2 gives round half up at the end.
    // Its top bits seed the remainder; they are always below the divisor since
    // the quotient never reaches 2^QUO_W.
    always_comb begin
        big       = (fore_sum > back_sum) ? fore_sum : back_sum;
        small_sum = (fore_sum > back_sum) ? back_sum : fore_sum;
        numer     = {big, {RATIO_FRAC_BITS{1'b0}}} + NUM_W'(small_sum >> 1);
        n_lane.divisor = small_sum;
        n_lane.rem     = SUM_W'(numer >> QUO_W);
        n_lane.num     = numer[QUO_W-1:0];
        n_lane.quo     = '0;
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    rcr_divider u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_vld_lane),
        .i_lane (r_lane),
        .o_vld  (div_vld),
        .o_lane (div_lane)
    );

    // Clamp to 1.0 .. 21.0; the exact sums keep the quotient inside anyway.
    always_comb begin
        if (div_lane.quo < RATIO_LOWEST) begin
            n_ratio = RATIO_LOWEST;
        end else if (div_lane.quo > RATIO_HIGHEST) begin
            n_ratio = RATIO_HIGHEST;
        end else begin
            n_ratio = div_lane.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_vld;
        end
    end

    // Compare the clamped ratio, not the raw quotient, against the minimum.
    always_ff @(posedge i_clk) begin
        r_ratio <= n_ratio;
        r_meets <= n_ratio >= r_min_ratio;
    end

    assign o_ratio         = r_ratio;
    assign o_meets_minimum = r_meets;
    assign o_strobe        = r_strobe;

    // Every transaction taken is handed over: as it leaves the output register the strobe
    // rises and holds for one cycle.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##17 o_strobe)
        else $error("result strobe missing after accepted transaction");

    // The darker sum always carries the 0.05 offset, so the divisor is never zero,
    // and the seed remainder sits below it.
    a_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_lane |-> (r_lane.divisor >= SUM_OFFSET) && (r_lane.rem < r_lane.divisor))
        else $error("division lane entered with bad divisor or remainder");

    // The final remainder must stay below the divisor after the last cell.
    a_remainder : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld |-> div_lane.rem < div_lane.divisor)
        else $error("division remainder not reduced");

    // Exact sums keep the quotient inside 1.0 .. 21.0 without clamping.
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld |-> (div_lane.quo >= RATIO_LOWEST) && (div_lane.quo <= RATIO_HIGHEST))
        else $error("quotient left the 1.0 .. 21.0 range");

endmodule

@@ verif/rgb_contrast_ratio_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_contrast_ratio: feeds colour pairs on the command port,
// predicts every ratio and pass flag on its own and checks each strobed result in order.
// Depends on rcr_pkg (types and widths) and the rgb_contrast_ratio RTL.
module rgb_contrast_ratio_tb;
    import rcr_pkg::*;

    localparam int HALF_PERIOD      = 4;
    localparam int RESET_CYCLES     = 6;
    localparam int DRAIN_CYCLES     = 24;       // pipe is 17 deep; allow some slack
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASES           = 10;
    localparam int RANDOM_PER_PHASE = 155;

    // Q30 working format of the linearisation
    localparam longint unsigned FX_ONE  = 64'd1 << 30;
    localparam longint unsigned FX_HALF = 64'd1 << 29;

    // Luminance weights in units of 1/10000, and 0.05 at the same scale
    localparam longint unsigned LUMA_WT_R = 2126;
    localparam longint unsigned LUMA_WT_G = 7152;
    localparam longint unsigned LUMA_WT_B = 722;
    localparam longint unsigned FLARE     = 64'd500 << LUMA_FRAC_BITS;

    typedef struct packed {
        t_colour fore;
        t_colour back;
    } t_pair;

    typedef struct packed {
        t_ratio ratio;
        logic   meets;
    } t_verdict;

    logic    i_clk           = 1'b0;
    logic    i_rst_n         = 1'b0;
    logic    start           = 1'b0;
    logic    busy;
    t_colour i_fore_colour   = '0;
    t_colour i_back_colour   = '0;
    t_ratio  o_ratio;
    logic    o_meets_minimum;
    logic    o_strobe;
    logic    i_cfg_valid     = 1'b0;
    logic    o_cfg_ready;
    t_ratio  i_cfg_data      = '0;

    t_luma    srgb_lin [0:255];     // predicted linear light per 8-bit code
    t_ratio   floor_ratio;          // predicted min_ratio register
    t_pair    pending [$];          // colour pairs still to be offered
    t_verdict ratio_due [$];        // verdicts of accepted pairs, oldest first
    t_pair    next_pair;
    t_verdict seen_want;
    int       hold_off  = 0;        // remaining cycles of the current idle burst
    int       idle_pct  = 0;        // chance per offer of starting an idle burst
    int       mismatches = 0;
    int       cycles     = 0;

    rgb_contrast_ratio u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_fore_colour   (i_fore_colour),
        .i_back_colour   (i_back_colour),
        .o_ratio         (o_ratio),
        .o_meets_minimum (o_meets_minimum),
        .o_strobe        (o_strobe),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Q30 product, rounded half up
    function automatic longint unsigned fx_mul(input longint unsigned x,
                                               input longint unsigned y);
        return (x * y + FX_HALF) >> 30;
    endfunction

    // sRGB decode of one channel code. Below the knee the curve is linear;
    // above it the 2.4 power is built as the square times its fifth root,
    // the root found by bisection on the rounded fifth power.
    function automatic t_luma decode_channel(input int unsigned code);
        longint unsigned c64;
        longint unsigned lin;
        longint unsigned base;
        longint unsigned sq;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p2;
        longint unsigned p4;
        c64 = code;
        if (c64 <= 10) begin
            lin = (c64 * 10 * FX_ONE + 16473) / 32946;
        end else begin
            base = ((c64 * 1000 + 14025) * FX_ONE + 134512) / 269025;
            sq   = fx_mul(base, base);
            lo   = 0;
            hi   = FX_ONE;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                p2  = fx_mul(mid, mid);
                p4  = fx_mul(p2, p2);
                if (fx_mul(p4, mid) <= sq) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            lin = fx_mul(sq, lo);
        end
        return t_luma'((lin + (64'd1 << (29 - LUMA_FRAC_BITS))) >> (30 - LUMA_FRAC_BITS));
    endfunction

    // Relative luminance plus flare, kept exact at 10000 * 2^LUMA_FRAC_BITS
    function automatic longint unsigned light_sum(input t_colour rgb);
        return LUMA_WT_R * srgb_lin[rgb[23:16]] + LUMA_WT_G * srgb_lin[rgb[15:8]]
             + LUMA_WT_B * srgb_lin[rgb[7:0]] + FLARE;
    endfunction

    // Lighter over darker, rounded half up, clamped to 1.0 .. 21.0; the
    // pass flag compares the rounded ratio against the current minimum.
    function automatic t_verdict contrast_of(input t_colour fore, input t_colour back);
        longint unsigned f;
        longint unsigned k;
        longint unsigned big;
        longint unsigned least;
        longint unsigned q;
        t_verdict        v;
        f     = light_sum(fore);
        k     = light_sum(back);
        big   = (f > k) ? f : k;
        least = (f > k) ? k : f;
        if (least == 0) begin
            least = 1;
        end
        q = ((big << RATIO_FRAC_BITS) + least / 2) / least;
        if (q < (64'd1 << RATIO_FRAC_BITS)) begin
            q = 64'd1 << RATIO_FRAC_BITS;
        end
        if (q > (64'd21 << RATIO_FRAC_BITS)) begin
            q = 64'd21 << RATIO_FRAC_BITS;
        end
        v.ratio = t_ratio'(q);
        v.meets = (v.ratio >= floor_ratio);
        return v;
    endfunction

    // Channel code biased towards the knee of the curve and the ends of the range
    function automatic logic [7:0] edge_channel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd10;
            3:       return 8'd11;
            4:       return 8'd12;
            5:       return 8'd128;
            6:       return 8'd254;
            7:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the head of the pending queue, hold it until busy is
    // low at an edge, then record the verdict the block owes for it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            hold_off <= 0;
        end else if (!start || !busy) begin
            // a transaction completes at this edge when start was up and busy down
            if (start) begin
                ratio_due = {ratio_due, contrast_of(i_fore_colour, i_back_colour)};
            end
            if (hold_off != 0) begin
                // inside an idle burst: drop start and scramble the colour ports
                hold_off      <= hold_off - 1;
                start         <= 1'b0;
                i_fore_colour <= t_colour'($urandom);
                i_back_colour <= t_colour'($urandom);
            end else if (pending.size() != 0 && idle_pct != 0
                         && $urandom_range(99) < idle_pct) begin
                // open an idle burst of random length, this cycle included
                hold_off      <= $urandom_range(8, 0);
                start         <= 1'b0;
                i_fore_colour <= t_colour'($urandom);
                i_back_colour <= t_colour'($urandom);
            end else if (pending.size() != 0) begin
                next_pair      = pending.pop_front();
                i_fore_colour <= next_pair.fore;
                i_back_colour <= next_pair.back;
                start         <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest outstanding verdict.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (ratio_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result ratio=%0d meets=%0b",
                                          o_ratio, o_meets_minimum));
            end else begin
                seen_want = ratio_due.pop_front();
                if (o_ratio !== seen_want.ratio) begin
                    report_mismatch($sformatf("ratio got %0d want %0d",
                                              o_ratio, seen_want.ratio));
                end
                if (o_meets_minimum !== seen_want.meets) begin
                    report_mismatch($sformatf("meets_minimum got %b want %b (ratio %0d, min %0d)",
                                              o_meets_minimum, seen_want.meets,
                                              seen_want.ratio, floor_ratio));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL rgb_contrast_ratio");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: directed pairs at the reset minimum, then one phase per
    // minimum setting, each written while the pipe is empty.
    // ------------------------------------------------------------------
    initial begin
        int unsigned floor_plan [PHASES];
        int unsigned idle_plan [PHASES];
        t_pair       p;
        logic [7:0]  grey;

        for (int i = 0; i < 256; i++) begin
            srgb_lin[i] = decode_channel(i);
        end
        floor_ratio = t_ratio'(1152);     // 4.5 out of reset

        // extremes first (1.0, 21.0, 0 and 8191), then typical and random minima
        floor_plan = '{256, 5376, 0, 8191, 768, 1152, 0, 0, 0, 0};
        for (int i = 6; i < PHASES; i++) begin
            floor_plan[i] = $urandom_range(5376, 256);
        end
        // idle bursts in every phase but phase 3 and the last, which run back to back
        idle_plan = '{25, 40, 10, 0, 30, 15, 35, 20, 45, 0};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs: black and white both ways, equal colours, the
        // primaries, codes either side of the linear knee and greys just
        // either side of 4.5 against white, so the threshold is met and missed.
        @(negedge i_clk);
        idle_pct = 20;
        pending = '{
            {24'h000000, 24'hFFFFFF},
            {24'hFFFFFF, 24'h000000},
            {24'h000000, 24'h000000},
            {24'hFFFFFF, 24'hFFFFFF},
            {24'h767676, 24'hFFFFFF},
            {24'h777777, 24'hFFFFFF},
            {24'hFFFFFF, 24'h757575},
            {24'h595959, 24'hFFFFFF},
            {24'h0A0A0A, 24'h0B0B0B},
            {24'h0B0000, 24'h000A00},
            {24'h00000A, 24'h00000B},
            {24'h010101, 24'h000000},
            {24'hFF0000, 24'h000000},
            {24'h00FF00, 24'h000000},
            {24'h0000FF, 24'h000000},
            {24'hFFFFFF, 24'h0000FF},
            {24'hAAAAAA, 24'h555555},
            {24'h123456, 24'hEDCBA9},
            {24'h800000, 24'h008000},
            {24'hFEFEFE, 24'h010101}
        };

        for (int ph = 0; ph < PHASES; ph++) begin
            // wait until the pipe has delivered everything it owes
            do @(negedge i_clk); while (pending.size() != 0 || start || ratio_due.size() != 0);

            // write the new minimum and follow it in the prediction once taken
            @(posedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= t_ratio'(floor_plan[ph]);
            do @(posedge i_clk); while (!o_cfg_ready);
            floor_ratio  = t_ratio'(floor_plan[ph]);
            i_cfg_valid <= 1'b0;
            i_cfg_data  <= t_ratio'($urandom);

            @(negedge i_clk);
            idle_pct = idle_plan[ph];
            repeat (RANDOM_PER_PHASE) begin
                p.fore = t_colour'($urandom);
                p.back = t_colour'($urandom);
                case ($urandom_range(9))
                    4, 5: begin
                        // near neighbours: ratios close to 1.0
                        p.back = p.fore ^ (24'h070707 & t_colour'($urandom));
                    end
                    6, 7: begin
                        p.fore = {edge_channel(), edge_channel(), edge_channel()};
                        p.back = {edge_channel(), edge_channel(), edge_channel()};
                    end
                    8: begin
                        grey   = 8'($urandom);
                        p.fore = {3{grey}};
                        grey   = 8'($urandom);
                        p.back = {3{grey}};
                    end
                    9: begin
                        p.back = p.fore;
                    end
                    default: begin
                        // fully random pair, already set
                    end
                endcase
                pending = {pending, p};
            end
        end

        do @(negedge i_clk); while (pending.size() != 0 || start || ratio_due.size() != 0);
        // hold a little longer so a stray late strobe is still caught
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS rgb_contrast_ratio");
        end else begin
            $display("FAIL rgb_contrast_ratio");
        end
        $finish;
    end

endmodule
